/* sv/csvfs_pkg.sv */
// shared types and constants of the csv field splitter
`timescale 1ns / 1ps

package csvfs_pkg;

  localparam int unsigned ColW   = 10;
  localparam int unsigned CountW = 32;
  localparam int unsigned PosW   = 16;

  localparam logic [ColW-1:0] MAX_COLUMNS = ColW'(1023);

  localparam logic [7:0] LF_BYTE = 8'd10;
  localparam logic [7:0] CR_BYTE = 8'd13;

  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  // configuration register indexes
  localparam logic CFG_DELIMITER = 1'b0;
  localparam logic CFG_QUOTE     = 1'b1;

  // quote tracking states
  localparam logic [1:0] QS_OUTSIDE     = 2'd0;
  localparam logic [1:0] QS_INSIDE      = 2'd1;
  localparam logic [1:0] QS_AFTER_QUOTE = 2'd2;
  localparam logic [1:0] QS_SKIP_LF     = 2'd3;

  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_FIELD_END = 3'd1,
    KIND_ROW_END   = 3'd2,
    KIND_COL_ERR   = 3'd3,
    KIND_BAD_CHAR  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data_byte;
    logic [ColW-1:0]   column_count;
    logic [ColW-1:0]   expected_columns;
    logic [CountW-1:0] row_index;
    logic [CountW-1:0] line_number;
    logic [PosW-1:0]   char_position;
  } result_t;

  typedef struct packed {
    logic push;
    logic halted;
  } status_t;

endpackage

/* sv/csv_field_splitter_top.sv */
// top level of the csv field splitter
`timescale 1ns / 1ps

// Splits a CSV byte stream into field content bytes, field ends and row ends.
// Input channel: one request per byte (in_byte_i), or an end marker
// (end_of_text_i) that closes the last field and row and then halts the block.
// Output channel: at most one result per request, with kind, data byte and
// the column, row, line and position counters at that point.
// Configuration: cfg_we_i writes the delimiter (index 0) or the quote byte
// (index 1); write only while no request is in flight.
// Datapath: a request is held in the input register, and the parse step then
// loads the result register from it. Throughput is one byte per cycle while
// the receiver takes results, set by the single parse step between the two
// registers.
// Requests that give no result (quotes that open or close, lf after cr)
// still pass through the parse step. A column mismatch or a stray byte after a closing
// quote gives an error result and halts; a halted block keeps taking
// requests and drops them until reset. Reset restores delimiter ',' and
// quote '"' and clears all counters.
// When the receiver stalls, the result register holds and the input side
// stops once its register is full.

module csv_field_splitter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [7:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output csvfs_pkg::kind_e              kind_o,
  output logic [7:0]                    data_byte_o,
  output logic [csvfs_pkg::ColW-1:0]    column_count_o,
  output logic [csvfs_pkg::ColW-1:0]    expected_columns_o,
  output logic [csvfs_pkg::CountW-1:0]  row_index_o,
  output logic [csvfs_pkg::CountW-1:0]  line_number_o,
  output logic [csvfs_pkg::PosW-1:0]    char_position_o
);
  import csvfs_pkg::*;

  item_t   in_item, s1_item;
  logic    s1_valid, out_free, adv;
  result_t step_res, out_res;
  status_t stat;

  assign in_item.in_byte     = in_byte_i;
  assign in_item.end_of_text = end_of_text_i;

  assign adv = s1_valid && out_free;

  csvfs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  csvfs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .item_i      (s1_item),
    .result_o    (step_res),
    .status_o    (stat)
  );

  csvfs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (stat.push),
    .result_i    (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign kind_o             = out_res.kind;
  assign data_byte_o        = out_res.data_byte;
  assign column_count_o     = out_res.column_count;
  assign expected_columns_o = out_res.expected_columns;
  assign row_index_o        = out_res.row_index;
  assign line_number_o      = out_res.line_number;
  assign char_position_o    = out_res.char_position;

  // a result is only loaded when the output slot is free
  a_push_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.push |-> out_free)
    else $error("result loaded into an occupied output register");

  // once halted, no further results are produced
  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.halted |-> !stat.push)
    else $error("result produced while halted");

  // a row end after the first row always matches the header column count
  a_row_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_ROW_END && row_index_o != '0)
      |-> column_count_o == expected_columns_o)
    else $error("row end with mismatched column count");

  // only content results carry a data byte
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_BYTE) |-> data_byte_o == 8'd0)
    else $error("data byte set on a non-content result");

endmodule

/* sv/csvfs_in_stage.sv */
// input register holding one request for the parse stage
`timescale 1ns / 1ps

module csvfs_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  csvfs_pkg::item_t item_i,
  input  logic             adv_i,
  output logic             valid_o,
  output csvfs_pkg::item_t item_o
);
  import csvfs_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign in_ready_o = !valid_q || adv_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* sv/csvfs_parser.sv */
// quote tracking, field and row splitting, column check and counters
`timescale 1ns / 1ps

module csvfs_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               adv_i,
  input  csvfs_pkg::item_t   item_i,
  output csvfs_pkg::result_t result_o,
  output csvfs_pkg::status_t status_o
);
  import csvfs_pkg::*;

  logic [7:0]        delim_q, quote_q;
  logic [1:0]        qs_q, qs_d, qs_cur;
  logic [ColW-1:0]   col_q, col_d, col_inc, hdr_q, hdr_d;
  logic [CountW-1:0] rows_q, rows_d, lines_q, lines_d;
  logic [PosW-1:0]   pos_q, pos_d, pos_n;
  logic              halted_q, halted_d;
  logic              eot, is_q, is_d, is_cr, is_lf, row_end;
  logic              emit, step;
  result_t           res;

  assign eot   = item_i.end_of_text;
  assign is_q  = !eot && (item_i.in_byte == quote_q);
  assign is_d  = !eot && (item_i.in_byte == delim_q);
  assign is_cr = !eot && (item_i.in_byte == CR_BYTE);
  assign is_lf = !eot && (item_i.in_byte == LF_BYTE);
  assign row_end = eot || is_cr || is_lf;

  assign step = adv_i && !halted_q;

  assign col_inc = (col_q < MAX_COLUMNS) ? col_q + 1'b1 : col_q;

  always_comb begin
    pos_n = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
    lines_d = lines_q;
    if (is_lf) begin
      pos_n = '0;
      if (lines_q != '1) begin
        lines_d = lines_q + 1'b1;
      end
    end
  end

  always_comb begin
    qs_cur   = (qs_q == QS_SKIP_LF) ? QS_OUTSIDE : qs_q;
    qs_d     = qs_cur;
    col_d    = col_q;
    hdr_d    = hdr_q;
    rows_d   = rows_q;
    pos_d    = pos_n;
    halted_d = halted_q;
    emit     = 1'b0;

    res.kind             = KIND_BYTE;
    res.data_byte        = '0;
    res.column_count     = col_q;
    res.expected_columns = hdr_q;
    res.row_index        = rows_q;
    res.line_number      = lines_d;
    res.char_position    = pos_n;

    if (qs_q == QS_SKIP_LF && is_lf) begin
      // lf right after a cr row end is swallowed
      qs_d = QS_OUTSIDE;
    end else if (qs_cur == QS_OUTSIDE && is_q) begin
      qs_d = QS_INSIDE;
    end else if (qs_cur == QS_INSIDE && is_q) begin
      qs_d = QS_AFTER_QUOTE;
    end else begin
      // doubled quote: back inside, the quote goes out as content
      if (qs_cur == QS_AFTER_QUOTE && is_q) begin
        qs_cur = QS_INSIDE;
      end
      emit = 1'b1;
      if (eot || (qs_cur != QS_INSIDE && (is_d || is_cr || is_lf))) begin
        qs_d = QS_OUTSIDE;
        col_d = col_inc;
        res.column_count = col_inc;
        if (!row_end) begin
          res.kind = KIND_FIELD_END;
        end else if (rows_q != '0 && hdr_q != col_inc) begin
          res.kind = KIND_COL_ERR;
          halted_d = 1'b1;
        end else begin
          res.kind = KIND_ROW_END;
          if (rows_q == '0) begin
            hdr_d = col_inc;
            res.expected_columns = col_inc;
          end
          if (rows_q != '1) begin
            rows_d = rows_q + 1'b1;
          end
          col_d    = '0;
          pos_d    = '0;
          qs_d     = is_cr ? QS_SKIP_LF : QS_OUTSIDE;
          halted_d = eot;
        end
      end else if (qs_cur == QS_AFTER_QUOTE) begin
        res.kind = KIND_BAD_CHAR;
        halted_d = 1'b1;
      end else begin
        res.data_byte = item_i.in_byte;
        qs_d = qs_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q  <= DELIM_RESET;
      quote_q  <= QUOTE_RESET;
      qs_q     <= QS_OUTSIDE;
      col_q    <= '0;
      hdr_q    <= '0;
      rows_q   <= '0;
      lines_q  <= '0;
      pos_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DELIMITER: delim_q <= cfg_wdata_i;
          CFG_QUOTE:     quote_q <= cfg_wdata_i;
          default:       delim_q <= delim_q;
        endcase
      end
      if (step) begin
        qs_q     <= qs_d;
        col_q    <= col_d;
        hdr_q    <= hdr_d;
        rows_q   <= rows_d;
        lines_q  <= lines_d;
        pos_q    <= pos_d;
        halted_q <= halted_d;
      end
    end
  end

  assign result_o        = res;
  assign status_o.push   = step && emit;
  assign status_o.halted = halted_q;

endmodule

/* sv/csvfs_out_reg.sv */
// result register toward the receiver
`timescale 1ns / 1ps

module csvfs_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  csvfs_pkg::result_t result_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output csvfs_pkg::result_t result_o
);
  import csvfs_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule
